// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files; the top-level expander includes them.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/sre_pkg.sv -----
`timescale 1ns / 1ps

package sre_pkg;

  // Default sprite size in pixels.
  localparam int SPRITE_PIXELS_DEF = 1024;

  // Widths of the result fields.
  localparam int START_W = 10;
  localparam int LEN_W   = 11;

  // Depth of the queue between parser and output stage (a power of two).
  localparam int QUEUE_DEPTH = 4;

  // Alpha values of transparent and coloured runs.
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_KEY_RED   = 2'd0,
    REG_KEY_GREEN = 2'd1,
    REG_KEY_BLUE  = 2'd2
  } reg_index_t;

  // Transparent key colour.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } key_t;

  // One run descriptor as it leaves the block.
  typedef struct packed {
    logic [START_W-1:0] run_start;
    logic [LEN_W-1:0]   run_length;
    logic [7:0]         pix_red;
    logic [7:0]         pix_green;
    logic [7:0]         pix_blue;
    logic [7:0]         pix_alpha;
    logic               overflowed;
    logic               sprite_done;
  } run_t;

  // Everything one byte produces: one run, and optionally a second.
  typedef struct packed {
    run_t first;
    logic has_second;
    run_t second;
  } entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- rtl/sre_byte_if.sv -----
`timescale 1ns / 1ps

// Compressed byte stream channel.
interface sre_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/sre_run_if.sv -----
`timescale 1ns / 1ps

// Run descriptor channel.
interface sre_run_if;
  logic        valid;
  logic        ready;
  logic [9:0]  run_start;
  logic [10:0] run_length;
  logic [7:0]  pix_red;
  logic [7:0]  pix_green;
  logic [7:0]  pix_blue;
  logic [7:0]  pix_alpha;
  logic        overflowed;
  logic        sprite_done;

  modport source (
    output valid, output run_start, output run_length, output pix_red,
    output pix_green, output pix_blue, output pix_alpha, output overflowed,
    output sprite_done, input ready
  );
  modport sink (
    input valid, input run_start, input run_length, input pix_red,
    input pix_green, input pix_blue, input pix_alpha, input overflowed,
    input sprite_done, output ready
  );
endinterface

// ----- rtl/sre_cfg_if.sv -----
`timescale 1ns / 1ps

// Configuration write channel.
interface sre_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sre_front.sv -----
`timescale 1ns / 1ps

// Record parser: walks the field phases of each record, tracks the pixel
// cursor and turns every byte into zero, one or two run descriptors.
module sre_front #(
  parameter int SPRITE_PIXELS = sre_pkg::SPRITE_PIXELS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  sre_byte_if.sink        byte_in,
  input  sre_pkg::key_t   key,
  input  sre_pkg::qstat_t q_stat,
  output logic            q_push,
  output sre_pkg::entry_t q_entry
);
  import sre_pkg::*;

  localparam int CW = $clog2(SPRITE_PIXELS + 1);

  typedef enum logic [2:0] {
    PH_T_LO,
    PH_T_HI,
    PH_C_LO,
    PH_C_HI,
    PH_RED,
    PH_GREEN,
    PH_BLUE
  } phase_t;

  phase_t       phase, phase_next;
  logic [CW-1:0] cursor;
  logic [CW-1:0] room;
  logic [15:0]  colored_left, colored_next;
  logic [7:0]   low_hold;
  logic [7:0]   red_hold;
  logic [7:0]   green_hold;
  logic         ovf;

  logic          accept;
  logic [15:0]   count;
  logic          t_clip;
  logic          a_valid;
  logic [CW-1:0] a_len;
  logic          ovf_next;
  logic [CW-1:0] cursor_mid;
  logic [CW-1:0] room_mid;
  run_t          run_a;
  run_t          run_b;
  run_t          run_mark;

  // A byte is taken whenever the queue has space.
  assign byte_in.ready = ~q_stat.full;
  assign accept        = byte_in.valid & byte_in.ready;

  // Classify the byte against the current phase.
  assign count  = {byte_in.data_byte, low_hold};
  assign t_clip = count > 16'(room);

  always_comb begin
    phase_next   = phase;
    colored_next = colored_left;
    a_valid      = 1'b0;
    a_len        = '0;
    ovf_next     = ovf;
    run_a        = '0;
    unique case (phase)
      PH_T_LO:  phase_next = PH_T_HI;
      PH_T_HI: begin
        a_len      = t_clip ? room : CW'(count);
        a_valid    = a_len != '0;
        ovf_next   = ovf | t_clip;
        phase_next = PH_C_LO;
      end
      PH_C_LO:  phase_next = PH_C_HI;
      PH_C_HI: begin
        colored_next = count;
        phase_next   = (count != 16'd0) ? PH_RED : PH_T_LO;
      end
      PH_RED:   phase_next = PH_GREEN;
      PH_GREEN: phase_next = PH_BLUE;
      PH_BLUE: begin
        a_valid      = room != '0;
        a_len        = a_valid ? CW'(1) : '0;
        ovf_next     = ovf | ~a_valid;
        colored_next = colored_left - 16'd1;
        phase_next   = (colored_next != 16'd0) ? PH_RED : PH_T_LO;
      end
      default:  phase_next = PH_T_LO;
    endcase

    // Colour of the run this byte makes, if any.
    run_a.run_start   = START_W'(cursor);
    run_a.run_length  = LEN_W'(a_len);
    run_a.overflowed  = ovf_next;
    run_a.sprite_done = 1'b0;
    if (phase == PH_BLUE) begin
      run_a.pix_red   = red_hold;
      run_a.pix_green = green_hold;
      run_a.pix_blue  = byte_in.data_byte;
      run_a.pix_alpha = ALPHA_OPAQUE;
    end else begin
      run_a.pix_red   = key.red;
      run_a.pix_green = key.green;
      run_a.pix_blue  = key.blue;
      run_a.pix_alpha = ALPHA_CLEAR;
    end
  end

  assign cursor_mid = cursor + a_len;
  assign room_mid   = room - a_len;

  // Fill run to the end of the sprite, and the marker for a full sprite.
  always_comb begin
    run_b             = '0;
    run_b.run_start   = START_W'(cursor_mid);
    run_b.run_length  = LEN_W'(room_mid);
    run_b.pix_red     = key.red;
    run_b.pix_green   = key.green;
    run_b.pix_blue    = key.blue;
    run_b.pix_alpha   = ALPHA_CLEAR;
    run_b.overflowed  = ovf_next;
    run_b.sprite_done = 1'b1;
    run_mark            = run_b;
    run_mark.run_start  = '0;
    run_mark.run_length = '0;
  end

  // Pack the byte's results into one queue entry, first result in front.
  always_comb begin
    q_entry            = '0;
    q_entry.first      = run_a;
    q_entry.second     = run_b;
    q_entry.has_second = 1'b0;
    if (byte_in.last_byte) begin
      if (room_mid != '0) begin
        if (a_valid) begin
          q_entry.has_second = 1'b1;
        end else begin
          q_entry.first = run_b;
        end
      end else if (a_valid) begin
        q_entry.first.sprite_done = 1'b1;
      end else begin
        q_entry.first = run_mark;
      end
    end
  end

  assign q_push = accept & (a_valid | byte_in.last_byte);

  // Parser state; the last byte returns the sprite to its start.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_T_LO;
      cursor       <= '0;
      room         <= CW'(SPRITE_PIXELS);
      colored_left <= '0;
      ovf          <= 1'b0;
    end else if (accept) begin
      if (phase == PH_T_LO || phase == PH_C_LO) begin
        low_hold <= byte_in.data_byte;
      end
      if (phase == PH_RED) begin
        red_hold <= byte_in.data_byte;
      end
      if (phase == PH_GREEN) begin
        green_hold <= byte_in.data_byte;
      end
      if (byte_in.last_byte) begin
        phase        <= PH_T_LO;
        cursor       <= '0;
        room         <= CW'(SPRITE_PIXELS);
        colored_left <= '0;
        ovf          <= 1'b0;
      end else begin
        phase        <= phase_next;
        cursor       <= cursor_mid;
        room         <= room_mid;
        colored_left <= colored_next;
        ovf          <= ovf_next;
      end
    end
  end

endmodule

// ----- rtl/sre_queue.sv -----
`timescale 1ns / 1ps

// Small first-in first-out queue of result entries between parser and
// output stage.
module sre_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sre_pkg::entry_t push_entry,
  input  logic            pop,
  output sre_pkg::entry_t head,
  output sre_pkg::qstat_t status
);
  import sre_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign status.full  = count == CNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign head         = slots[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/sre_back.sv -----
`timescale 1ns / 1ps

// Output stage: takes queue entries and presents their runs one per
// transfer from an output register, holding a second run aside.
module sre_back (
  input  logic            clk,
  input  logic            rst,
  input  sre_pkg::entry_t head,
  input  sre_pkg::qstat_t q_stat,
  output logic            pop,
  sre_run_if.source       run_out
);
  import sre_pkg::*;

  logic out_valid;
  run_t out_data;
  logic pend_valid;
  run_t pend_data;
  logic load;

  // The output register may be refilled when empty or being taken.
  assign load = ~out_valid | run_out.ready;
  assign pop  = load & ~pend_valid & ~q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_data   <= pend_data;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_stat.empty) begin
        out_data   <= head.first;
        out_valid  <= 1'b1;
        pend_data  <= head.second;
        pend_valid <= head.has_second;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Drive the channel from the output register.
  assign run_out.valid       = out_valid;
  assign run_out.run_start   = out_data.run_start;
  assign run_out.run_length  = out_data.run_length;
  assign run_out.pix_red     = out_data.pix_red;
  assign run_out.pix_green   = out_data.pix_green;
  assign run_out.pix_blue    = out_data.pix_blue;
  assign run_out.pix_alpha   = out_data.pix_alpha;
  assign run_out.overflowed  = out_data.overflowed;
  assign run_out.sprite_done = out_data.sprite_done;

endmodule

// ----- rtl/sprite_run_length_expander.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sprite run-length expander. Compressed sprite bytes enter on byte_in, one
// per transfer, and the block issues run descriptors (start, length, colour,
// alpha) on run_out; transparent runs use the key colour written through cfg
// and alpha 0, coloured pixels come out as single-pixel runs with alpha 255.
// A byte is accepted in every cycle while the four-entry result queue has
// room; a run reaches run_out via a queue slot and the output register. Each
// byte makes at most one run, except the last byte of a sprite, which can
// make two and then occupies the output register for two transfers; the
// output register issues one run per cycle while run_out is ready. Write the
// key colour only while the block is idle.
module sprite_run_length_expander #(
  parameter int SPRITE_PIXELS = sre_pkg::SPRITE_PIXELS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sre_cfg_if.sink    cfg,
  sre_byte_if.sink   byte_in,
  sre_run_if.source  run_out
);
  import sre_pkg::*;

  key_t   key;
  logic   q_push;
  logic   q_pop;
  entry_t q_entry;
  entry_t q_head;
  qstat_t q_stat;

  // Key colour registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KEY_RED:   key.red   <= cfg.data;
        REG_KEY_GREEN: key.green <= cfg.data;
        REG_KEY_BLUE:  key.blue  <= cfg.data;
        default:       key       <= key;
      endcase
    end
  end

  // Record parser.
  sre_front #(
    .SPRITE_PIXELS(SPRITE_PIXELS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .key     (key),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Result queue.
  sre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_stat)
  );

  // Output stage.
  sre_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_stat  (q_stat),
    .pop     (q_pop),
    .run_out (run_out)
  );

  // Queue never overrun or underrun.
  `ASSERT_IMPLIES(a_no_push_full, clk, rst, q_push, !q_stat.full)
  `ASSERT_IMPLIES(a_no_pop_empty, clk, rst, q_pop, !q_stat.empty)
  // The last byte of a sprite always yields a result.
  `ASSERT_IMPLIES(a_last_pushes, clk, rst,
                  byte_in.valid && byte_in.ready && byte_in.last_byte, q_push)
  // Only the end-of-sprite marker carries an empty run.
  `ASSERT_IMPLIES(a_empty_run_done, clk, rst,
                  run_out.valid && run_out.run_length == '0, run_out.sprite_done)

endmodule
